// ===== design/cgm_pkg.sv =====
// shared types and constants for the colour gradient map
`default_nettype none
package cgm_pkg;

  localparam int DEF_MAX_STOPS  = 4;
  localparam int DEF_VALUE_BITS = 16;

  localparam int STOP_REGS  = 4;
  localparam int CHANNELS   = 4;
  localparam int CH_W       = 8;
  localparam int POS_W      = 16;
  localparam int COLOR_W    = CHANNELS * CH_W;
  localparam int NUM_W      = CH_W + POS_W;
  localparam int DIV_STEPS  = CH_W;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W + COLOR_W;
  localparam int OUT_W      = COLOR_W;

  localparam logic [CNT_W-1:0] CNT_RESET = 3'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ENTRY_0 = 3'd1;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } stop_t;

  // interpolation request: lo/hi colours, span d, offset n, and d - n
  typedef struct packed {
    logic [COLOR_W-1:0] lo_color;
    logic [COLOR_W-1:0] hi_color;
    logic [POS_W-1:0]   d;
    logic [POS_W-1:0]   n;
    logic [POS_W-1:0]   dmn;
  } blend_req_t;

  // per-channel numerators sharing one divisor
  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0] num;
    logic [POS_W-1:0]               d;
  } div_req_t;

  function automatic stop_t stop_reset(input int k);
    stop_t s;
    s = '0;
    case (k)
      0: s = '{pos: 16'h0000, color: 32'h0000_00FF};
      1: s = '{pos: 16'h7FFF, color: 32'hFFFF_FFFF};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] color, input int c);
    return color[COLOR_W-1-CH_W*c -: CH_W];
  endfunction

endpackage
`default_nettype wire

// ===== design/cgm_cfg_regs.sv =====
// configuration registers: stop count and stop entries
`default_nettype none
module cgm_cfg_regs #(
  parameter int MAX_STOPS = cgm_pkg::DEF_MAX_STOPS,
  localparam int SLOTS = (MAX_STOPS < cgm_pkg::STOP_REGS) ? MAX_STOPS : cgm_pkg::STOP_REGS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cgm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cgm_pkg::stop_t                        stops_o [SLOTS],
  output logic [cgm_pkg::CNT_W-1:0]             count_o
);

  cgm_pkg::stop_t                stop_r [SLOTS];
  logic [cgm_pkg::CNT_W-1:0]     count_r;

  // zero means one stop, anything past the slots means all slots
  function automatic logic [cgm_pkg::CNT_W-1:0] clamp_count(
    input logic [cgm_pkg::CNT_W-1:0] raw
  );
    logic [cgm_pkg::CNT_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = cgm_pkg::CNT_W'(1);
    end else if (raw > cgm_pkg::CNT_W'(SLOTS)) begin
      res = cgm_pkg::CNT_W'(SLOTS);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= clamp_count(cgm_pkg::CNT_RESET);
      for (int k = 0; k < SLOTS; k++) begin
        stop_r[k] <= cgm_pkg::stop_reset(k);
      end
    end else if (cfg_we) begin
      if (cfg_index == cgm_pkg::REG_STOP_COUNT) begin
        count_r <= clamp_count(cfg_data[cgm_pkg::CNT_W-1:0]);
      end
      for (int k = 0; k < SLOTS; k++) begin
        if (cfg_index == cgm_pkg::CFG_IDX_W'(cgm_pkg::REG_STOP_ENTRY_0 + k)) begin
          stop_r[k] <= cgm_pkg::stop_t'(cfg_data);
        end
      end
    end
  end

  assign stops_o = stop_r;
  assign count_o = count_r;

endmodule
`default_nettype wire

// ===== design/cgm_locate.sv =====
// stop search and span set-up, two pipeline stages
`default_nettype none
module cgm_locate #(
  parameter int MAX_STOPS  = cgm_pkg::DEF_MAX_STOPS,
  parameter int VALUE_BITS = cgm_pkg::DEF_VALUE_BITS,
  localparam int SLOTS = (MAX_STOPS < cgm_pkg::STOP_REGS) ? MAX_STOPS : cgm_pkg::STOP_REGS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv_i,
  input  wire logic                          vld_i,
  input  wire logic [VALUE_BITS-1:0]         sample_i,
  input  wire logic                          missing_i,
  input  cgm_pkg::stop_t                     stops_i [SLOTS],
  input  wire logic [cgm_pkg::CNT_W-1:0]     count_i,
  output logic                               vld_o,
  output cgm_pkg::blend_req_t                req_o
);

  localparam int VW = ((VALUE_BITS > cgm_pkg::POS_W) ? VALUE_BITS : cgm_pkg::POS_W) + 1;
  localparam int IW = $clog2(SLOTS);

  // stage 1: compare against every stop, pick the first at or above
  logic signed [VW-1:0] v_nxt;
  logic [SLOTS-1:0]     hit;
  logic [IW-1:0]        idx;
  logic                 any_hit;
  logic                 flat_nxt;
  logic [IW-1:0]        hi_idx_nxt;

  logic                 s1_vld_r;
  logic                 s1_miss_r;
  logic                 s1_flat_r;
  logic [IW-1:0]        s1_hi_idx_r;
  logic signed [VW-1:0] s1_v_r;

  always_comb begin
    v_nxt = VW'($signed(sample_i));
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = (cgm_pkg::CNT_W'(k) < count_i) &&
               (VW'($signed(stops_i[k].pos)) >= v_nxt);
    end
    idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        idx = IW'(k);
      end
    end
    any_hit    = |hit;
    flat_nxt   = missing_i || !any_hit || (idx == '0);
    hi_idx_nxt = any_hit ? idx : IW'(count_i - cgm_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv_i) begin
      s1_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      s1_miss_r   <= missing_i;
      s1_flat_r   <= flat_nxt;
      s1_hi_idx_r <= hi_idx_nxt;
      s1_v_r      <= v_nxt;
    end
  end

  // stage 2: fetch the pair and form span and offsets
  logic [IW-1:0]        lo_idx;
  cgm_pkg::stop_t       e_hi;
  cgm_pkg::stop_t       e_lo;
  logic signed [VW-1:0] p_hi;
  logic signed [VW-1:0] p_lo;
  logic [VW-1:0]        d_full;
  logic [VW-1:0]        n_full;
  logic [VW-1:0]        dmn_full;
  cgm_pkg::blend_req_t  req_nxt;

  logic                 s2_vld_r;
  cgm_pkg::blend_req_t  s2_req_r;

  always_comb begin
    lo_idx   = (s1_hi_idx_r == '0) ? '0 : s1_hi_idx_r - IW'(1);
    e_hi     = stops_i[s1_hi_idx_r];
    e_lo     = stops_i[lo_idx];
    p_hi     = VW'($signed(e_hi.pos));
    p_lo     = VW'($signed(e_lo.pos));
    d_full   = VW'(p_hi - p_lo);
    n_full   = VW'(s1_v_r - p_lo);
    dmn_full = VW'(p_hi - s1_v_r);
    if (s1_flat_r) begin
      // plain colour: divide it by one
      req_nxt.lo_color = s1_miss_r ? '1 : e_hi.color;
      req_nxt.hi_color = '0;
      req_nxt.d        = cgm_pkg::POS_W'(1);
      req_nxt.n        = '0;
      req_nxt.dmn      = cgm_pkg::POS_W'(1);
    end else begin
      req_nxt.lo_color = e_lo.color;
      req_nxt.hi_color = e_hi.color;
      req_nxt.d        = d_full[cgm_pkg::POS_W-1:0];
      req_nxt.n        = n_full[cgm_pkg::POS_W-1:0];
      req_nxt.dmn      = dmn_full[cgm_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv_i) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      s2_req_r <= req_nxt;
    end
  end

  assign vld_o = s2_vld_r;
  assign req_o = s2_req_r;

`ifndef NO_ASSERTIONS
  a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_req_r.d != '0) && (s2_req_r.n <= s2_req_r.d) &&
                 (32'(s2_req_r.n) + 32'(s2_req_r.dmn) == 32'(s2_req_r.d)))
    else $error("span set-up out of range");
`endif

endmodule
`default_nettype wire

// ===== design/cgm_blend.sv =====
// weighted sums of the two stop colours, two pipeline stages
`default_nettype none
module cgm_blend (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv_i,
  input  wire logic          vld_i,
  input  cgm_pkg::blend_req_t req_i,
  output logic               vld_o,
  output cgm_pkg::div_req_t  req_o
);

  localparam int NW = cgm_pkg::NUM_W;

  logic [NW-1:0]              prod_lo_nxt [cgm_pkg::CHANNELS];
  logic [NW-1:0]              prod_hi_nxt [cgm_pkg::CHANNELS];
  logic [NW-1:0]              prod_lo_r   [cgm_pkg::CHANNELS];
  logic [NW-1:0]              prod_hi_r   [cgm_pkg::CHANNELS];
  logic [cgm_pkg::POS_W-1:0]  d_a_r;
  logic                       vld_a_r;

  cgm_pkg::div_req_t          req_nxt;
  cgm_pkg::div_req_t          req_r;
  logic                       vld_r;

  always_comb begin
    for (int c = 0; c < cgm_pkg::CHANNELS; c++) begin
      prod_lo_nxt[c] = NW'(cgm_pkg::chan_of(req_i.lo_color, c)) * NW'(req_i.dmn);
      prod_hi_nxt[c] = NW'(cgm_pkg::chan_of(req_i.hi_color, c)) * NW'(req_i.n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (adv_i) begin
      vld_a_r <= vld_i;
      vld_r   <= vld_a_r;
    end
  end

  // rounding term d/2 joins the two products
  always_comb begin
    req_nxt.d = d_a_r;
    for (int c = 0; c < cgm_pkg::CHANNELS; c++) begin
      req_nxt.num[c] = prod_lo_r[c] + prod_hi_r[c] + NW'(d_a_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
      d_a_r     <= req_i.d;
      req_r     <= req_nxt;
    end
  end

  assign vld_o = vld_r;
  assign req_o = req_r;

endmodule
`default_nettype wire

// ===== design/cgm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, four channels
`default_nettype none
module cgm_div (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    adv_i,
  input  wire logic                                    vld_i,
  input  cgm_pkg::div_req_t                            req_i,
  output logic                                         vld_o,
  output logic [cgm_pkg::CHANNELS-1:0][cgm_pkg::CH_W-1:0] quot_o
);

  localparam int STEPS = cgm_pkg::DIV_STEPS;
  localparam int NW    = cgm_pkg::NUM_W;
  localparam int CH    = cgm_pkg::CHANNELS;
  localparam int QW    = cgm_pkg::CH_W;

  logic [CH-1:0][NW-1:0]    rem_r [STEPS-1];
  logic [cgm_pkg::POS_W-1:0] d_r  [STEPS-1];
  logic [CH-1:0][QW-1:0]    q_r   [STEPS];
  logic                     vld_r [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int SH = STEPS - 1 - j;

    logic [CH-1:0][NW-1:0]     rem_in;
    logic [cgm_pkg::POS_W-1:0] d_in;
    logic [CH-1:0][QW-1:0]     q_in;
    logic                      v_in;
    logic [NW-1:0]             d_sh;
    logic [CH-1:0]             ge;
    logic [CH-1:0][QW-1:0]     q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = req_i.num;
      assign d_in   = req_i.d;
      assign q_in   = '0;
      assign v_in   = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
      assign v_in   = vld_r[j-1];
    end

    always_comb begin
      d_sh = NW'(d_in) << SH;
      for (int c = 0; c < CH; c++) begin
        ge[c]    = rem_in[c] >= d_sh;
        q_nxt[c] = {q_in[c][QW-2:0], ge[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv_i) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv_i) begin
        q_r[j] <= q_nxt;
      end
    end

    if (j < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv_i) begin
          d_r[j] <= d_in;
          for (int c = 0; c < CH; c++) begin
            rem_r[j][c] <= ge[c] ? rem_in[c] - d_sh : rem_in[c];
          end
        end
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign quot_o = q_r[STEPS-1];

`ifndef NO_ASSERTIONS
  // quotient must fit in one channel: numerator below 256 times the divisor
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i |-> (req_i.num[0] < {req_i.d, 8'h00}) && (req_i.num[1] < {req_i.d, 8'h00}) &&
              (req_i.num[2] < {req_i.d, 8'h00}) && (req_i.num[3] < {req_i.d, 8'h00}))
    else $error("divider numerator too large for an 8-bit quotient");
`endif

endmodule
`default_nettype wire

// ===== design/color_gradient_map_top.sv =====
// top level of the piecewise-linear colour gradient map
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------
//  in_      | request   | in_tvalid/in_tready  | tdata: sample_value; tuser: missing
//  out_     | result    | out_tvalid/out_tready| tdata: red, green, blue, alpha
//  cfg_     | write     | cfg_we               | cfg_index, cfg_data
//
// one request per clock while the output is not stalled; a result passes through
// 2 search stages, 2 blend stages and 8 divider stages, the last of which is
// the output register
// rst_n is synchronous: valid bits clear, stops return to black-to-white
// a stall on out_tready freezes the whole pipeline; in_tready comes from a
// one-entry skid register, so it never depends on out_tready in the same cycle
`default_nettype none
module color_gradient_map_top #(
  parameter int MAX_STOPS  = cgm_pkg::DEF_MAX_STOPS,
  parameter int VALUE_BITS = cgm_pkg::DEF_VALUE_BITS,
  localparam int SLOTS = (MAX_STOPS < cgm_pkg::STOP_REGS) ? MAX_STOPS : cgm_pkg::STOP_REGS,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [IN_W-1:0]                in_tdata,  // sample_value
  input  wire logic                           in_tuser,  // sample_missing
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [cgm_pkg::OUT_W-1:0]           out_tdata, // red, green, blue, alpha
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [cgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cgm_pkg::CFG_DATA_W-1:0] cfg_data
);

  cgm_pkg::stop_t             stops [SLOTS];
  logic [cgm_pkg::CNT_W-1:0]  stop_count;

  // pipeline advances whenever the output register is free or being drained
  logic                       adv;
  logic                       in_take;

  logic                       skid_valid_r;
  logic [VALUE_BITS-1:0]      skid_sample_r;
  logic                       skid_miss_r;

  logic                       feed_vld;
  logic [VALUE_BITS-1:0]      feed_sample;
  logic                       feed_miss;

  logic                       loc_vld;
  cgm_pkg::blend_req_t        loc_req;
  logic                       bld_vld;
  cgm_pkg::div_req_t          bld_req;
  logic                       div_vld;
  logic [cgm_pkg::CHANNELS-1:0][cgm_pkg::CH_W-1:0] quot;

  assign adv       = !div_vld || out_tready;
  assign in_tready = !skid_valid_r;
  assign in_take   = in_tvalid && in_tready;

  // skid entry goes first; a fresh request only bypasses when the skid is empty
  assign feed_vld    = skid_valid_r || in_take;
  assign feed_sample = skid_valid_r ? skid_sample_r : in_tdata[VALUE_BITS-1:0];
  assign feed_miss   = skid_valid_r ? skid_miss_r : in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (adv) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_take && !adv) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r && in_take && !adv) begin
      skid_sample_r <= in_tdata[VALUE_BITS-1:0];
      skid_miss_r   <= in_tuser;
    end
  end

  cgm_cfg_regs #(
    .MAX_STOPS (MAX_STOPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stops_o   (stops),
    .count_o   (stop_count)
  );

  cgm_locate #(
    .MAX_STOPS  (MAX_STOPS),
    .VALUE_BITS (VALUE_BITS)
  ) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .vld_i     (feed_vld),
    .sample_i  (feed_sample),
    .missing_i (feed_miss),
    .stops_i   (stops),
    .count_i   (stop_count),
    .vld_o     (loc_vld),
    .req_o     (loc_req)
  );

  cgm_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .adv_i (adv),
    .vld_i (loc_vld),
    .req_i (loc_req),
    .vld_o (bld_vld),
    .req_o (bld_req)
  );

  cgm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .vld_i  (bld_vld),
    .req_i  (bld_req),
    .vld_o  (div_vld),
    .quot_o (quot)
  );

  // red in the lowest byte, alpha in the highest
  assign out_tvalid = div_vld;
  assign out_tdata  = {quot[3], quot[2], quot[1], quot[0]};

`ifndef NO_ASSERTIONS
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && adv) |=> !skid_valid_r)
    else $error("skid entry not released after the pipeline advanced");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !adv) |=> skid_valid_r && $stable(skid_sample_r) && $stable(skid_miss_r))
    else $error("skid entry lost or changed during a stall");
`endif

endmodule
`default_nettype wire
